// ===== hdl/bipc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Isolated pixel cleanup package
// Shared types and constants for the four-neighbor isolated pixel filter.
// ----------------------------------------------------------------------------
package bipc_pkg;

  localparam int CFG_W             = 11;
  localparam int PIXEL_W           = 8;
  localparam int ROW_W             = 10;
  localparam int DEFAULT_MAX_WIDTH = 1024;

  localparam logic [CFG_W-1:0]   DIM_RESET    = 11'd1024;
  localparam logic [CFG_W-1:0]   HEIGHT_LIMIT = 11'd1024;
  localparam logic [PIXEL_W-1:0] WHITE        = 8'd255;
  localparam logic [PIXEL_W-1:0] BLACK        = 8'd0;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PIXEL_W-1:0] cleaned_pixel;
    logic               frame_end;
  } result_t;

endpackage

// ===== hdl/binary_isolated_pixel_cleanup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary isolated pixel cleanup
// Four-neighbor isolated pixel removal on a raster stream, one row of delay.
// ----------------------------------------------------------------------------
// One item is accepted per clock while the skid entry is empty; a result is registered
// (in the skid entry if the output stalls) and refers to the pixel one row above that item.
// The line memories are read one column ahead so that no access waits.
// A two-entry output stage lets one item in while a result is stalled.
// Reset restores 1024 by 1024 and restarts the frame; line memories keep data.
module binary_isolated_pixel_cleanup #(
  parameter int MAX_WIDTH = bipc_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          action,
  input  logic [bipc_pkg::PIXEL_W-1:0]  pixel,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [bipc_pkg::PIXEL_W-1:0]  cleaned_pixel,
  output logic                          frame_end,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [bipc_pkg::CFG_W-1:0]    cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [bipc_pkg::CFG_W-1:0]   image_width;
  logic [bipc_pkg::CFG_W-1:0]   image_height;
  logic [CW-1:0]                col;
  logic [CW-1:0]                col_next;
  logic [bipc_pkg::ROW_W-1:0]   row;
  logic [bipc_pkg::ROW_W-1:0]   row_next;
  logic                         draining;
  logic                         draining_next;
  logic [bipc_pkg::PIXEL_W-1:0] left_cleaned;
  logic [bipc_pkg::PIXEL_W-1:0] left_cleaned_next;

  logic [CW:0]                  width_eff;
  logic [bipc_pkg::CFG_W-1:0]   height_eff;
  logic                         last_col;
  logic                         last_row;
  logic                         restart;

  logic                         accept;
  logic                         is_pix;
  logic                         is_flush;
  logic                         produce;
  logic                         up_ok;
  logic                         left_ok;
  logic                         right_ok;
  logic                         all_zero;
  logic                         all_white;
  logic [bipc_pkg::PIXEL_W-1:0] res;
  bipc_pkg::result_t            result_new;

  logic [bipc_pkg::PIXEL_W-1:0] up_pixel;
  logic [bipc_pkg::PIXEL_W-1:0] self_pixel;
  logic [bipc_pkg::PIXEL_W-1:0] right_pixel;

  bipc_pkg::result_t            out_data;
  bipc_pkg::result_t            skid_data;
  logic                         skid_valid;
  logic                         out_free;

  // Effective image size.
  always_comb begin
    if (image_width == '0) begin
      width_eff = (CW+1)'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      width_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      width_eff = (CW+1)'(image_width);
    end
    if (image_height == '0) begin
      height_eff = bipc_pkg::CFG_W'(1);
    end else if (image_height > bipc_pkg::HEIGHT_LIMIT) begin
      height_eff = bipc_pkg::HEIGHT_LIMIT;
    end else begin
      height_eff = image_height;
    end
  end

  assign last_col = ({1'b0, col} + (CW+1)'(1)) >= width_eff;
  assign last_row = ({1'b0, row} + bipc_pkg::CFG_W'(1)) >= height_eff;
  assign restart  = cfg_write;

  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign is_pix     = accept && (action == bipc_pkg::ACT_PIXEL) && !draining;
  assign is_flush   = accept && (action == bipc_pkg::ACT_FLUSH) && draining;
  assign produce    = (is_pix && (row != '0)) || is_flush;

  // Neighbor rule: all present neighbors black gives black, all white gives white.
  assign up_ok    = is_flush ? (row != '0) : (row > bipc_pkg::ROW_W'(1));
  assign left_ok  = (col != '0);
  assign right_ok = !last_col;

  assign all_zero  = (!up_ok || (up_pixel == bipc_pkg::BLACK)) &&
                     (!is_pix || (pixel == bipc_pkg::BLACK)) &&
                     (!left_ok || (left_cleaned == bipc_pkg::BLACK)) &&
                     (!right_ok || (right_pixel == bipc_pkg::BLACK));
  assign all_white = (!up_ok || (up_pixel == bipc_pkg::WHITE)) &&
                     (!is_pix || (pixel == bipc_pkg::WHITE)) &&
                     (!left_ok || (left_cleaned == bipc_pkg::WHITE)) &&
                     (!right_ok || (right_pixel == bipc_pkg::WHITE));

  always_comb begin
    if (all_zero) begin
      res = bipc_pkg::BLACK;
    end else if (all_white) begin
      res = bipc_pkg::WHITE;
    end else begin
      res = self_pixel;
    end
    result_new.cleaned_pixel = res;
    result_new.frame_end     = is_flush && last_col;
  end

  // Frame position.
  always_comb begin
    col_next          = col;
    row_next          = row;
    draining_next     = draining;
    left_cleaned_next = left_cleaned;
    if (restart) begin
      col_next          = '0;
      row_next          = '0;
      draining_next     = 1'b0;
      left_cleaned_next = bipc_pkg::BLACK;
    end else begin
      if (produce) begin
        left_cleaned_next = res;
      end
      if (is_pix) begin
        if (last_col) begin
          col_next = '0;
          if (last_row) begin
            draining_next = 1'b1;
          end else begin
            row_next = row + bipc_pkg::ROW_W'(1);
          end
        end else begin
          col_next = col + CW'(1);
        end
      end else if (is_flush) begin
        if (last_col) begin
          col_next          = '0;
          row_next          = '0;
          draining_next     = 1'b0;
          left_cleaned_next = bipc_pkg::BLACK;
        end else begin
          col_next = col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bipc_pkg::DIM_RESET;
      image_height <= bipc_pkg::DIM_RESET;
      col          <= '0;
      row          <= '0;
      draining     <= 1'b0;
      left_cleaned <= bipc_pkg::BLACK;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          bipc_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          bipc_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end
      col          <= col_next;
      row          <= row_next;
      draining     <= draining_next;
      left_cleaned <= left_cleaned_next;
    end
  end

  // Line memories: write at current column, read at next transaction's column (+1 for right).
  bipc_ram #(.WIDTH(bipc_pkg::PIXEL_W), .DEPTH(MAX_WIDTH)) u_cleaned_line (
    .clk   (clk),
    .we    (produce),
    .waddr (col),
    .wdata (res),
    .raddr (col_next),
    .rdata (up_pixel)
  );

  bipc_ram #(.WIDTH(bipc_pkg::PIXEL_W), .DEPTH(MAX_WIDTH)) u_original_self (
    .clk   (clk),
    .we    (is_pix),
    .waddr (col),
    .wdata (pixel),
    .raddr (col_next),
    .rdata (self_pixel)
  );

  bipc_ram #(.WIDTH(bipc_pkg::PIXEL_W), .DEPTH(MAX_WIDTH)) u_original_right (
    .clk   (clk),
    .we    (is_pix),
    .waddr (col),
    .wdata (pixel),
    .raddr (col_next + CW'(1)),
    .rdata (right_pixel)
  );

  // Output register with one skid entry.
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : result_new;
    end else if (produce) begin
      skid_data <= result_new;
    end
  end

  assign cleaned_pixel = out_data.cleaned_pixel;
  assign frame_end     = out_data.frame_end;

  // The skid entry is only ever occupied behind a held result.
  a_skid_behind_result : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry valid without a held result");

  // A result produced against a stalled output must land in the skid entry.
  a_skid_fill : assert property (@(posedge clk) disable iff (rst)
    (produce && result_valid && result_stall) |=> skid_valid)
    else $error("result lost while output stalled");

  // The column never leaves the current row.
  a_col_range : assert property (@(posedge clk) disable iff (rst)
    ({1'b0, col} < width_eff))
    else $error("column beyond image width");

  // Draining happens only on the last row of the frame.
  a_drain_last_row : assert property (@(posedge clk) disable iff (rst)
    draining |-> last_row)
    else $error("draining before the last row");

endmodule

// ===== hdl/bipc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic line memory
// Single write port, single registered read port, write-first on a collision.
// ----------------------------------------------------------------------------
module bipc_ram #(
  parameter int WIDTH = bipc_pkg::PIXEL_W,
  parameter int DEPTH = bipc_pkg::DEFAULT_MAX_WIDTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule
